// ----- hw/rtl/i2ctrf_pkg.sv -----
// Shared types and constants for the I2C target register file.
package i2ctrf_pkg;

   localparam int REGISTER_SLOTS = 8;
   localparam int IDX_W = (REGISTER_SLOTS > 1) ? $clog2(REGISTER_SLOTS) : 1;
   localparam int COUNT_W = 4;
   localparam int ADDR_W = 7;
   localparam int BYTE_W = 8;
   localparam int NOTIFY_IDX_W = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;
   // Largest effective count: the number of register slots, capped at 15 for the 4-bit count register.
   localparam int ACTIVE_MAX = (REGISTER_SLOTS > 15) ? 15 : REGISTER_SLOTS;

   typedef enum logic [1:0] {
      ACT_START    = 2'd0,
      ACT_OVERFLOW = 2'd1,
      ACT_HOST_WR  = 2'd2,
      ACT_TICK     = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      RESP_RELEASE  = 3'd0,
      RESP_ACK      = 3'd1,
      RESP_RECV     = 3'd2,
      RESP_SEND     = 3'd3,
      RESP_RECV_ACK = 3'd4,
      RESP_NOTIFY   = 3'd5
   } resp_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEVICE_ADDRESS = 2'd0,
      CSR_REGISTER_COUNT = 2'd1
   } csr_index_type;

   // Write request into the register memory.
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [BYTE_W-1:0] data;
   } mem_wr_type;

   // Invalidate every entry at or above clr_from.
   typedef struct packed {
      logic               en;
      logic [COUNT_W-1:0] clr_from;
   } mem_clr_type;

   function automatic logic [COUNT_W-1:0] active_count(input logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0] lim;
      lim = COUNT_W'(ACTIVE_MAX);
      return (count > lim) ? lim : count;
   endfunction

endpackage

// ----- hw/rtl/i2ctrf_regmem.sv -----
// Register data memory with registered read and per-entry valid bits (invalid reads zero).
module i2ctrf_regmem (
   input  logic                             clock,
   input  logic                             reset,
   input  i2ctrf_pkg::mem_wr_type           wr,
   input  i2ctrf_pkg::mem_clr_type          clr,
   input  logic                             rd_en,
   input  logic [i2ctrf_pkg::IDX_W-1:0]     rd_addr,
   output logic [i2ctrf_pkg::BYTE_W-1:0]    rd_data
);
   import i2ctrf_pkg::*;

   logic [BYTE_W-1:0]         mem [REGISTER_SLOTS];
   logic [REGISTER_SLOTS-1:0] valid_ff;
   logic [REGISTER_SLOTS-1:0] valid_in;
   logic [BYTE_W-1:0]         rd_data_ff;
   logic                      rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (clr.en) begin
         for (int i = 0; i < REGISTER_SLOTS; i++) begin
            if (32'(i) >= 32'(clr.clr_from)) valid_in[i] = 1'b0;
         end
      end
      if (wr.en) valid_in[wr.addr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wr.en) mem[wr.addr] <= wr.data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- hw/rtl/i2c_target_register_file_core.sv -----
// Byte-level I2C target serving a small register file: bus phase control and dispatch.
// A bus event's result is registered from ST_EMIT, or ST_SEND for a send, once the output
//   register is free; a send's memory read starts in the accepting cycle, and no request
//   is taken meanwhile. A host write, an ignored overflow or an empty tick retires in its
//   accepting cycle; a tick reports each pending register through ST_TICK_RD then ST_TICK_OUT.
// Synchronous active-high reset clears control, pending marks and memory valid bits at once.
module i2c_target_register_file_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request: tdata = shifted_byte[7:0], sda_low_at_start[8], host_index[16:9],
   //          host_value[24:17], zero fill
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [i2ctrf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [1:0]                           req_tuser,   // action
   // response: tdata = tx_byte[7:0], notify_index[10:8], notify_value[18:11], zero fill
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [i2ctrf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [2:0]                           rsp_tuser,   // bus_response
   output logic                                 rsp_tlast,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [i2ctrf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [i2ctrf_pkg::CSR_DATA_W-1:0]    csr_data
);
   import i2ctrf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMIT,
      ST_SEND,
      ST_TICK_RD,
      ST_TICK_OUT
   } state_type;

   typedef enum logic [2:0] {
      PH_ADDR     = 3'd0,
      PH_SET_RX   = 3'd1,
      PH_RX       = 3'd2,
      PH_SET_TX   = 3'd3,
      PH_TX       = 3'd4,
      PH_CHECK_TX = 3'd5
   } phase_type;

   state_type                 state_ff, state_in;
   phase_type                 phase_ff, phase_in;
   logic                      listening_ff, listening_in;
   logic                      ptr_valid_ff, ptr_valid_in;
   logic [IDX_W-1:0]          ptr_ff, ptr_in;
   logic [REGISTER_SLOTS-1:0] pending_ff, pending_in;
   logic [REGISTER_SLOTS-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0]          tick_idx_ff, tick_idx_in;
   resp_type                  res_ff, res_in;
   logic [ADDR_W-1:0]         dev_addr_ff, dev_addr_in;
   logic [COUNT_W-1:0]        count_ff, count_in;

   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   resp_type                  rsp_tuser_ff, rsp_tuser_in;
   logic [RSP_TDATA_W-1:0]    rsp_tdata_ff, rsp_tdata_in;
   logic                      rsp_tlast_ff, rsp_tlast_in;

   mem_wr_type                mem_wr;
   mem_clr_type               mem_clr;
   logic                      rd_en;
   logic [IDX_W-1:0]          rd_addr;
   logic [BYTE_W-1:0]         rd_data;

   action_type                action;
   logic [BYTE_W-1:0]         in_byte;
   logic                      in_sda_low;
   logic [BYTE_W-1:0]         in_host_idx;
   logic [BYTE_W-1:0]         in_host_val;
   logic [COUNT_W-1:0]        active;
   logic [COUNT_W-1:0]        new_active;
   logic [REGISTER_SLOTS-1:0] count_mask;
   logic                      out_free;
   logic                      try_send;
   logic [IDX_W-1:0]          scan_sel;
   logic [REGISTER_SLOTS-1:0] scan_rest;

   assign action      = action_type'(req_tuser);
   assign in_byte     = req_tdata[7:0];
   assign in_sda_low  = req_tdata[8];
   assign in_host_idx = req_tdata[16:9];
   assign in_host_val = req_tdata[24:17];

   assign active     = active_count(count_ff);
   assign new_active = active_count(csr_data[COUNT_W-1:0]);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      for (int i = 0; i < REGISTER_SLOTS; i++) begin
         count_mask[i] = (32'(i) < 32'(active));
      end
   end

   // lowest pending entry still to report
   always_comb begin
      scan_sel = '0;
      for (int i = REGISTER_SLOTS - 1; i >= 0; i--) begin
         if (scan_ff[i]) scan_sel = IDX_W'(i);
      end
      scan_rest = scan_ff;
      scan_rest[scan_sel] = 1'b0;
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      listening_in  = listening_ff;
      ptr_valid_in  = ptr_valid_ff;
      ptr_in        = ptr_ff;
      pending_in    = pending_ff;
      scan_in       = scan_ff;
      tick_idx_in   = tick_idx_ff;
      res_in        = res_ff;
      dev_addr_in   = dev_addr_ff;
      count_in      = count_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      mem_wr        = '0;
      mem_clr       = '0;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff;
      try_send      = 1'b0;

      if (rsp_tready) rsp_tvalid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (action)
                  ACT_START: begin
                     phase_in     = PH_ADDR;
                     listening_in = in_sda_low;
                     res_in       = in_sda_low ? RESP_RECV : RESP_RELEASE;
                     state_in     = ST_EMIT;
                  end
                  ACT_OVERFLOW: begin
                     if (listening_ff) begin
                        state_in = ST_EMIT;
                        case (phase_ff)
                           PH_SET_RX: begin
                              phase_in = PH_RX;
                              res_in   = RESP_RECV;
                           end
                           PH_RX: begin
                              phase_in = PH_SET_RX;
                              if (ptr_valid_ff) begin
                                 mem_wr.en          = 1'b1;
                                 mem_wr.addr        = ptr_ff;
                                 mem_wr.data        = in_byte;
                                 pending_in[ptr_ff] = 1'b1;
                                 ptr_in             = '0;
                                 ptr_valid_in       = 1'b0;
                                 res_in             = RESP_ACK;
                              end else if (in_byte >= BYTE_W'(active)) begin
                                 listening_in = 1'b0;
                                 res_in       = RESP_RELEASE;
                              end else begin
                                 ptr_valid_in = 1'b1;
                                 ptr_in       = in_byte[IDX_W-1:0];
                                 res_in       = RESP_ACK;
                              end
                           end
                           PH_CHECK_TX: begin
                              if (in_byte != '0) begin
                                 ptr_valid_in = 1'b0;
                                 ptr_in       = '0;
                                 listening_in = 1'b0;
                                 res_in       = RESP_RELEASE;
                              end else begin
                                 try_send = 1'b1;
                              end
                           end
                           PH_SET_TX: try_send = 1'b1;
                           PH_TX: begin
                              phase_in = PH_CHECK_TX;
                              res_in   = RESP_RECV_ACK;
                           end
                           default: begin
                              if (in_byte[7:1] == dev_addr_ff) begin
                                 phase_in = in_byte[0] ? PH_SET_TX : PH_SET_RX;
                                 res_in   = RESP_ACK;
                              end else begin
                                 listening_in = 1'b0;
                                 res_in       = RESP_RELEASE;
                              end
                           end
                        endcase
                        if (try_send) begin
                           if (!ptr_valid_ff) begin
                              listening_in = 1'b0;
                              res_in       = RESP_RELEASE;
                           end else begin
                              phase_in     = PH_TX;
                              rd_en        = 1'b1;
                              rd_addr      = ptr_ff;
                              ptr_in       = '0;
                              ptr_valid_in = 1'b0;
                              state_in     = ST_SEND;
                           end
                        end
                     end
                  end
                  ACT_HOST_WR: begin
                     if (in_host_idx < BYTE_W'(active)) begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = in_host_idx[IDX_W-1:0];
                        mem_wr.data = in_host_val;
                        pending_in[in_host_idx[IDX_W-1:0]] = 1'b1;
                     end
                  end
                  ACT_TICK: begin
                     scan_in = pending_ff & count_mask;
                     if ((pending_ff & count_mask) != '0) state_in = ST_TICK_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = res_ff;
               rsp_tdata_in  = '0;
               rsp_tlast_in  = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = RESP_SEND;
               rsp_tdata_in  = RSP_TDATA_W'(rd_data);
               rsp_tlast_in  = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_TICK_RD: begin
            rd_en                = 1'b1;
            rd_addr              = scan_sel;
            tick_idx_in          = scan_sel;
            scan_in              = scan_rest;
            pending_in[scan_sel] = 1'b0;
            state_in             = ST_TICK_OUT;
         end
         ST_TICK_OUT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = RESP_NOTIFY;
               rsp_tdata_in  = RSP_TDATA_W'({rd_data, NOTIFY_IDX_W'(tick_idx_ff), {BYTE_W{1'b0}}});
               rsp_tlast_in  = (scan_ff == '0);
               state_in      = (scan_ff == '0) ? ST_IDLE : ST_TICK_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS: dev_addr_in = csr_data[ADDR_W-1:0];
            CSR_REGISTER_COUNT: begin
               count_in         = csr_data[COUNT_W-1:0];
               mem_clr.en       = 1'b1;
               mem_clr.clr_from = new_active;
               for (int i = 0; i < REGISTER_SLOTS; i++) begin
                  if (32'(i) >= 32'(new_active)) pending_in[i] = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_ADDR;
         listening_ff  <= 1'b0;
         ptr_valid_ff  <= 1'b0;
         ptr_ff        <= '0;
         pending_ff    <= '0;
         scan_ff       <= '0;
         dev_addr_ff   <= '0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         listening_ff  <= listening_in;
         ptr_valid_ff  <= ptr_valid_in;
         ptr_ff        <= ptr_in;
         pending_ff    <= pending_in;
         scan_ff       <= scan_in;
         dev_addr_ff   <= dev_addr_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      tick_idx_ff  <= tick_idx_in;
      res_ff       <= res_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   i2ctrf_regmem u_regmem (
      .clock   (clock),
      .reset   (reset),
      .wr      (mem_wr),
      .clr     (mem_clr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

// ----- hw/rtl/i2ctrf_checker.sv -----
// Port-level checks on the response channel, bound to the top level.
module i2ctrf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [i2ctrf_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [2:0]                          rsp_tuser,
   input logic                                rsp_tlast
);
   import i2ctrf_pkg::*;

   // only a notify closes a tick
   a_last_is_notify: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == RESP_NOTIFY)
      else $error("tlast on a non-notify response");

   a_tx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != RESP_SEND |-> rsp_tdata[7:0] == '0)
      else $error("tx byte set outside a send");

   a_notify_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != RESP_NOTIFY |-> rsp_tdata[18:8] == '0)
      else $error("notify fields set outside a notify");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("response changed while stalled");

endmodule

bind i2c_target_register_file_core i2ctrf_checker u_i2ctrf_checker (.*);
